// File: hw/rtl/hcbd_pkg.sv
// Shared types and constants for the chunked body decoder.
// Used by every module of the block; it depends on nothing else.
package hcbd_pkg;

  // Default width of the chunk size counter.
  localparam int unsigned SizeBitsDef = 32;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Character codes that the parser recognizes.
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChSp  = 8'h20;

  // Status codes carried on every output beat.
  localparam logic [1:0] StatusBusy     = 2'd0;
  localparam logic [1:0] StatusDone     = 2'd1;
  localparam logic [1:0] StatusSyntax   = 2'd2;
  localparam logic [1:0] StatusOverflow = 2'd3;

  // One input beat.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       start_message;
  } in_beat_t;

  // One output beat.
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       chunk_last;
    logic [1:0] status;
  } out_beat_t;

  // A classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
    logic       is_blank;
  } cls_t;

endpackage

// File: hw/rtl/hcbd_front.sv
// Front end of the chunked body decoder: accepts input beats and classifies bytes.
// Depends on hcbd_pkg; feeds hcbd_queue.
module hcbd_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hcbd_pkg::in_beat_t in_beat_i,
  input  logic               full_i,
  output logic               push_o,
  output hcbd_pkg::cls_t     push_cls_o
);
  import hcbd_pkg::*;

  logic [7:0] c;

  // The queue takes a beat whenever it has room.
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign c          = in_beat_i.byte_in;

  // Decode the byte into the classes the parser needs.
  always_comb begin
    push_cls_o          = '0;
    push_cls_o.data     = c;
    push_cls_o.start    = in_beat_i.start_message;
    push_cls_o.is_cr    = (c == ChCr);
    push_cls_o.is_lf    = (c == ChLf);
    push_cls_o.is_blank = (c == ChSp) || (c == ChTab);
    if (c >= 8'h30 && c <= 8'h39) begin
      push_cls_o.is_hex  = 1'b1;
      push_cls_o.hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // Letters a-f and A-F share their low three bits: 1..6 maps to 10..15.
      push_cls_o.is_hex  = 1'b1;
      push_cls_o.hex_val = 4'(c[2:0]) + 4'd9;
    end
  end

endmodule

// File: hw/rtl/hcbd_queue.sv
// Short queue of classified bytes between the front and the back.
// Depends on hcbd_pkg.
module hcbd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hcbd_pkg::cls_t push_cls_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           not_empty_o,
  output hcbd_pkg::cls_t pop_cls_o
);
  import hcbd_pkg::*;

  cls_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o      = (cnt_q == QueueCntW'(QueueDepth));
  assign not_empty_o = (cnt_q != '0);
  assign pop_cls_o   = mem_q[rd_ptr_q];

  // Entry storage; it needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cls_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/hcbd_back.sv
// Back end of the chunked body decoder: the parse state machine and output register.
// Depends on hcbd_pkg; drains hcbd_queue.
module hcbd_back #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SizeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_not_empty_i,
  input  hcbd_pkg::cls_t      q_cls_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hcbd_pkg::out_beat_t out_beat_o
);
  import hcbd_pkg::*;

  // Parse phase codes.
  localparam logic [3:0] PhSizeStart = 4'd0;
  localparam logic [3:0] PhSize      = 4'd1;
  localparam logic [3:0] PhSizeWs    = 4'd2;
  localparam logic [3:0] PhSizeLf    = 4'd3;
  localparam logic [3:0] PhData      = 4'd4;
  localparam logic [3:0] PhDataCr    = 4'd5;
  localparam logic [3:0] PhDataLf    = 4'd6;
  localparam logic [3:0] PhEndCr     = 4'd7;
  localparam logic [3:0] PhEndLf     = 4'd8;
  localparam logic [3:0] PhDone      = 4'd9;
  localparam logic [3:0] PhErrSyntax = 4'd10;
  localparam logic [3:0] PhErrOvf    = 4'd11;

  logic [3:0]           phase_q, phase_d, phase_cur;
  logic [SIZE_BITS-1:0] rem_q, rem_d, rem_cur, rem_dec;
  logic                 dv, last;
  logic [1:0]           status;
  logic                 out_valid_q;
  out_beat_t            out_beat_q;

  // Take the next byte whenever the output register is free or being drained.
  assign pop_o = q_not_empty_i && (!out_valid_q || !out_stall_i);

  // A new message restarts the size line before this byte is parsed.
  assign phase_cur = q_cls_i.start ? PhSizeStart : phase_q;
  assign rem_cur   = q_cls_i.start ? '0 : rem_q;
  assign rem_dec   = (rem_cur != '0) ? rem_cur - SIZE_BITS'(1) : rem_cur;

  // Next phase, counter and result for this byte.
  always_comb begin
    phase_d = phase_cur;
    rem_d   = rem_cur;
    dv      = 1'b0;
    last    = 1'b0;
    unique case (phase_cur) inside
      PhSizeStart: begin
        if (q_cls_i.is_hex) begin
          phase_d = PhSize;
          rem_d   = SIZE_BITS'(q_cls_i.hex_val);
        end else if (!(q_cls_i.is_blank || q_cls_i.is_cr || q_cls_i.is_lf)) begin
          phase_d = PhErrSyntax;
        end
      end
      PhSize: begin
        if (q_cls_i.is_hex) begin
          // Another digit must not push set bits out of the top nibble.
          if (rem_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_d = PhErrOvf;
          end else begin
            rem_d = {rem_cur[SIZE_BITS-5:0], q_cls_i.hex_val};
          end
        end else if (q_cls_i.is_cr) begin
          phase_d = PhSizeLf;
        end else if (q_cls_i.is_blank) begin
          phase_d = PhSizeWs;
        end else begin
          phase_d = PhErrSyntax;
        end
      end
      PhSizeWs: begin
        if (q_cls_i.is_cr) begin
          phase_d = PhSizeLf;
        end else if (!q_cls_i.is_blank) begin
          phase_d = PhErrSyntax;
        end
      end
      PhSizeLf: begin
        if (q_cls_i.is_lf) begin
          phase_d = (rem_cur == '0) ? PhEndCr : PhData;
        end else begin
          phase_d = PhErrSyntax;
        end
      end
      PhData: begin
        dv    = 1'b1;
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          last    = 1'b1;
          phase_d = PhDataCr;
        end
      end
      PhDataCr: phase_d = q_cls_i.is_cr ? PhDataLf : PhErrSyntax;
      PhDataLf: phase_d = q_cls_i.is_lf ? PhSizeStart : PhErrSyntax;
      PhEndCr:  phase_d = q_cls_i.is_cr ? PhEndLf : PhErrSyntax;
      PhEndLf:  phase_d = q_cls_i.is_lf ? PhDone : PhErrSyntax;
      PhDone, PhErrSyntax, PhErrOvf: begin
        phase_d = phase_cur;
      end
      default: phase_d = PhErrSyntax;
    endcase
  end

  // Status follows the phase after this byte.
  always_comb begin
    unique case (phase_d)
      PhDone:      status = StatusDone;
      PhErrSyntax: status = StatusSyntax;
      PhErrOvf:    status = StatusOverflow;
      default:     status = StatusBusy;
    endcase
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSizeStart;
      rem_q   <= '0;
    end else if (pop_o) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_beat_q.data_valid <= dv;
      out_beat_q.data_byte  <= dv ? q_cls_i.data : 8'd0;
      out_beat_q.chunk_last <= last;
      out_beat_q.status     <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

// File: hw/rtl/http_chunked_body_decoder_top.sv
// Top level of the HTTP chunked body decoder.
// Depends on hcbd_pkg, hcbd_front, hcbd_queue and hcbd_back.
//
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_beat_i) carries one body byte
//   per beat, with start_message set on the first byte of a new message. The
//   output channel (out_valid_o, out_stall_i, out_beat_o) returns exactly one
//   beat per input beat: the payload byte with data_valid and chunk_last, and
//   the parse status (in progress, complete, syntax error, size overflow).
//   A beat is taken at a rising edge with valid high and stall low.
//   An input beat is registered in the two-entry classify queue and then in
//   the output register. The block takes one beat every cycle while nothing
//   stalls; the parse state machine updates once per byte.
//   Reset clears the queue and the output valid flag, and returns the parser to the
//   start of a size line with a zero size count.
//   While the receiver stalls, the output beat holds and the queue fills; once
//   both queue entries are taken, in_stall_o rises until the output drains.
module http_chunked_body_decoder_top #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SizeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hcbd_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hcbd_pkg::out_beat_t out_beat_o
);
  import hcbd_pkg::*;

  logic push, full, pop, q_not_empty;
  cls_t push_cls, pop_cls;

  // Byte classification.
  hcbd_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .full_i     (full),
    .push_o     (push),
    .push_cls_o (push_cls)
  );

  // Decoupling queue.
  hcbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cls_i  (push_cls),
    .full_o      (full),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .pop_cls_o   (pop_cls)
  );

  // Parser and output register.
  hcbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_cls_i       (pop_cls),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_beat_o    (out_beat_o)
  );

  // A chunk's last byte is always a payload byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.chunk_last |-> out_beat_o.data_valid)
    else $error("chunk_last without data_valid");

  // Payload bytes only occur while the body is still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.data_valid |-> out_beat_o.status == StatusBusy)
    else $error("payload byte with a final status");

  // A queued byte reaches the output register as soon as the slot is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_not_empty && !(out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("queued byte not moved to the output");

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("push into full queue");

endmodule
